>>> design/tpjf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpjf_pkg: shared types and constants of the touch point jump filter
// Register indexes and reset values, sample, config, history and result
// structs used by the output interface, the filter datapath and the top.
// ----------------------------------------------------------------------------
package tpjf_pkg;

    // coordinate and register widths
    localparam int COORD_BITS   = 12;
    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 2;
    localparam int COUNT_BITS   = 4;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_JUMP_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH_ENABLE  = 2'd3;

    // register reset values
    localparam logic [CFG_BITS-1:0] RST_SCREEN_WIDTH   = 13'd240;
    localparam logic [CFG_BITS-1:0] RST_SCREEN_HEIGHT  = 13'd320;
    localparam logic [CFG_BITS-1:0] RST_JUMP_THRESHOLD = 13'd80;
    localparam logic                RST_SMOOTH_ENABLE  = 1'b1;

    // one raw controller sample
    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] x_high;
        logic [7:0] x_low;
        logic [7:0] y_high;
        logic [7:0] y_low;
    } t_sample;

    // configuration registers
    typedef struct packed {
        logic [CFG_BITS-1:0] screen_width;
        logic [CFG_BITS-1:0] screen_height;
        logic [CFG_BITS-1:0] jump_threshold;
        logic                smooth_enable;
    } t_cfg;

    // last accepted point
    typedef struct packed {
        logic                  has_prev;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_hist;

    // one result word
    typedef struct packed {
        logic [COUNT_BITS-1:0] point_count;
        logic                  touched;
        logic                  accepted;
        logic [COORD_BITS-1:0] x_out;
        logic [COORD_BITS-1:0] y_out;
    } t_result;

endpackage
`default_nettype wire

>>> design/tpjf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpjf_in_if: sample input channel
// Valid/ready channel carrying one raw touch sample per word.
// ----------------------------------------------------------------------------
interface tpjf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] y_high;
    logic [7:0] y_low;

    modport source (output valid, output status_byte, output x_high, output x_low,
                    output y_high, output y_low, input ready);
    modport sink   (input valid, input status_byte, input x_high, input x_low,
                    input y_high, input y_low, output ready);
endinterface
`default_nettype wire

>>> design/tpjf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpjf_out_if: filtered point output channel
// Valid/ready channel carrying one filtered touch result per word.
// ----------------------------------------------------------------------------
interface tpjf_out_if;
    import tpjf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] point_count;
    logic                  touched;
    logic                  accepted;
    logic [COORD_BITS-1:0] x_out;
    logic [COORD_BITS-1:0] y_out;

    modport source (output valid, output point_count, output touched, output accepted,
                    output x_out, output y_out, input ready);
    modport sink   (input valid, input point_count, input touched, input accepted,
                    input x_out, input y_out, output ready);
endinterface
`default_nettype wire

>>> design/touch_point_jump_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_point_jump_filter: touch coordinate jump reject and smoothing filter
// Input register, combinational filter datapath, output register.
// ----------------------------------------------------------------------------
// Each sample word gives exactly one result word. The block takes one word per
// cycle while the output is not stalled: the filter logic between the input and
// output registers resolves a sample and updates the stored history as it
// leaves the input register, so the next sample already sees it. A stalled
// output holds its word while one more sample waits in the input register. The
// user must write the configuration registers through i_cfg_we / i_cfg_idx /
// i_cfg_data only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module touch_point_jump_filter (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    tpjf_in_if.sink                       i_in,
    tpjf_out_if.source                    o_out,
    input  wire                           i_cfg_we,
    input  wire [tpjf_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire [tpjf_pkg::CFG_BITS-1:0]  i_cfg_data
);
    import tpjf_pkg::*;

    t_cfg    r_cfg;
    t_hist   r_hist;
    t_hist   n_hist;
    logic    r_in_valid;
    t_sample r_in_sample;
    logic    r_out_valid;
    t_result r_out_result;
    t_result n_result;
    t_sample in_sample;
    logic    advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width   <= RST_SCREEN_WIDTH;
            r_cfg.screen_height  <= RST_SCREEN_HEIGHT;
            r_cfg.jump_threshold <= RST_JUMP_THRESHOLD;
            r_cfg.smooth_enable  <= RST_SMOOTH_ENABLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCREEN_WIDTH:   r_cfg.screen_width   <= i_cfg_data;
                REG_SCREEN_HEIGHT:  r_cfg.screen_height  <= i_cfg_data;
                REG_JUMP_THRESHOLD: r_cfg.jump_threshold <= i_cfg_data;
                REG_SMOOTH_ENABLE:  r_cfg.smooth_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: the sample moves on when the output register is free
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign in_sample.status_byte = i_in.status_byte;
    assign in_sample.x_high      = i_in.x_high;
    assign in_sample.x_low       = i_in.x_low;
    assign in_sample.y_high      = i_in.y_high;
    assign in_sample.y_low       = i_in.y_low;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_sample <= in_sample;
        end
    end

    // filter datapath
    tpjf_filter u_filter (
        .i_sample (r_in_sample),
        .i_cfg    (r_cfg),
        .i_hist   (r_hist),
        .o_result (n_result),
        .o_hist   (n_hist)
    );

    // history, updated as each sample passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (advance) begin
            r_hist <= n_hist;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= n_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.point_count = r_out_result.point_count;
    assign o_out.touched     = r_out_result.touched;
    assign o_out.accepted    = r_out_result.accepted;
    assign o_out.x_out       = r_out_result.x_out;
    assign o_out.y_out       = r_out_result.y_out;

`ifndef ASSERT_OFF
    // a rejected or untouched word carries zero coordinates
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_result.accepted) |->
            (r_out_result.x_out == '0 && r_out_result.y_out == '0))
        else $error("rejected word with nonzero coordinates");

    // only a touched sample can be accepted
    a_accept_touched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_result.accepted) |-> r_out_result.touched)
        else $error("accepted word without touch");

    // an accepted point becomes the history
    a_hist_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_result.accepted) |=>
            (r_hist.has_prev && r_hist.x == r_out_result.x_out &&
             r_hist.y == r_out_result.y_out))
        else $error("history does not match accepted point");

    // a sample without touch drops the history
    a_no_touch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !n_result.touched) |=> !r_hist.has_prev)
        else $error("history kept after release");

    // a stalled word is not overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !advance)
        else $error("output word overwritten while stalled");
`endif

endmodule
`default_nettype wire

>>> design/tpjf_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpjf_filter: per-sample filter datapath
// Builds the coordinates, checks screen bounds and jump distance, applies
// quarter-weight smoothing and produces the result and the next history.
// ----------------------------------------------------------------------------
module tpjf_filter (
    input  tpjf_pkg::t_sample i_sample,
    input  tpjf_pkg::t_cfg    i_cfg,
    input  tpjf_pkg::t_hist   i_hist,
    output tpjf_pkg::t_result o_result,
    output tpjf_pkg::t_hist   o_hist
);
    import tpjf_pkg::*;

    logic [COUNT_BITS-1:0] count;
    logic                  touched;
    logic [COORD_BITS-1:0] nx;
    logic [COORD_BITS-1:0] ny;
    logic                  in_screen;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS:0]   jump_sum;
    logic                  jump_ok;
    logic [COORD_BITS+1:0] sum_x;
    logic [COORD_BITS+1:0] sum_y;
    logic [COORD_BITS-1:0] fx;
    logic [COORD_BITS-1:0] fy;
    logic                  accept;

    // decode sample
    assign count   = i_sample.status_byte[COUNT_BITS-1:0];
    assign touched = (count != '0);
    assign nx      = {i_sample.x_high[3:0], i_sample.x_low};
    assign ny      = {i_sample.y_high[3:0], i_sample.y_low};

    // screen bounds
    assign in_screen = ({1'b0, nx} < i_cfg.screen_width) &&
                       ({1'b0, ny} < i_cfg.screen_height);

    // Manhattan jump against the last accepted point
    assign dx       = (nx >= i_hist.x) ? (nx - i_hist.x) : (i_hist.x - nx);
    assign dy       = (ny >= i_hist.y) ? (ny - i_hist.y) : (i_hist.y - ny);
    assign jump_sum = {1'b0, dx} + {1'b0, dy};
    assign jump_ok  = !i_hist.has_prev || (jump_sum <= i_cfg.jump_threshold);

    // (3*old + new) / 4, floor
    assign sum_x = {1'b0, i_hist.x, 1'b0} + {2'b00, i_hist.x} + {2'b00, nx};
    assign sum_y = {1'b0, i_hist.y, 1'b0} + {2'b00, i_hist.y} + {2'b00, ny};

    always_comb begin
        if (i_hist.has_prev && i_cfg.smooth_enable) begin
            fx = sum_x[COORD_BITS+1:2];
            fy = sum_y[COORD_BITS+1:2];
        end else begin
            fx = nx;
            fy = ny;
        end
    end

    assign accept = touched && in_screen && jump_ok;

    // result word
    always_comb begin
        o_result.point_count = count;
        o_result.touched     = touched;
        o_result.accepted    = accept;
        o_result.x_out       = accept ? fx : '0;
        o_result.y_out       = accept ? fy : '0;
    end

    // history update: no touch drops it, accepted point replaces it
    always_comb begin
        o_hist = i_hist;
        if (!touched) begin
            o_hist.has_prev = 1'b0;
        end else if (accept) begin
            o_hist.has_prev = 1'b1;
            o_hist.x        = fx;
            o_hist.y        = fy;
        end
    end

endmodule
`default_nettype wire

>>> sim/touch_point_jump_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_point_jump_filter_tb: self-checking bench of the touch point filter
// Feeds raw touch samples through the valid/ready input channel, predicts
// each filtered point from a local copy of the config and point history, and
// compares every output word field by field. Phases change the screen size,
// jump limit and smoothing between idle points, and vary source gaps, sink
// stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module touch_point_jump_filter_tb;
    import tpjf_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;

    tpjf_in_if  smp_if ();
    tpjf_out_if pnt_if ();

    touch_point_jump_filter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (smp_if),
        .o_out      (pnt_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // mirrored config and point history
    logic [CFG_BITS-1:0]   scr_w = RST_SCREEN_WIDTH;
    logic [CFG_BITS-1:0]   scr_h = RST_SCREEN_HEIGHT;
    logic [CFG_BITS-1:0]   jump_max = RST_JUMP_THRESHOLD;
    logic                  smooth_on = RST_SMOOTH_ENABLE;
    logic [COORD_BITS-1:0] hist_x = '0;
    logic [COORD_BITS-1:0] hist_y = '0;
    logic                  hist_valid = 1'b0;

    t_sample sample_q [$];
    t_result point_q [$];
    t_sample next_word;
    t_result want;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int err_count = 0;
    int trk_x = 0;
    int trk_y = 0;
    logic hold_req = 1'b0;
    int   hold_cnt = 0;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t ns: mismatch %s: got %0d, expected %0d", $time, what, got, exp_val);
        err_count++;
    endtask

    // filtered point for one sample; advances the history
    function automatic t_result filter_point(input t_sample s);
        t_result               r;
        logic [COORD_BITS-1:0] nx;
        logic [COORD_BITS-1:0] ny;
        logic [CFG_BITS-1:0]   step_sum;
        logic [13:0]           sx;
        logic [13:0]           sy;
        r = '0;
        r.point_count = s.status_byte[3:0];
        r.touched = (s.status_byte[3:0] != 4'd0);
        if (!r.touched) begin
            hist_valid = 1'b0;
            return r;
        end
        nx = {s.x_high[3:0], s.x_low};
        ny = {s.y_high[3:0], s.y_low};
        if ({1'b0, nx} >= scr_w || {1'b0, ny} >= scr_h)
            return r;
        if (hist_valid) begin
            step_sum = ((nx > hist_x) ? nx - hist_x : hist_x - nx)
                     + ((ny > hist_y) ? ny - hist_y : hist_y - ny);
            if (step_sum > jump_max)
                return r;
            if (smooth_on) begin
                sx = 14'(hist_x * 3 + nx);
                sy = 14'(hist_y * 3 + ny);
                nx = sx[13:2];
                ny = sy[13:2];
            end
        end
        hist_x = nx;
        hist_y = ny;
        hist_valid = 1'b1;
        r.accepted = 1'b1;
        r.x_out = nx;
        r.y_out = ny;
        return r;
    endfunction

    // junk fills the ignored upper nibbles
    function automatic t_sample build_sample(input logic [3:0] cnt, input logic [11:0] x,
                                             input logic [11:0] y, input logic [11:0] junk);
        t_sample s;
        s.status_byte = {junk[3:0], cnt};
        s.x_high = {junk[7:4], x[11:8]};
        s.x_low = x[7:0];
        s.y_high = {junk[11:8], y[11:8]};
        s.y_low = y[7:0];
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[CFG_BITS-1:0];
        case (idx)
            REG_SCREEN_WIDTH:   scr_w = value[CFG_BITS-1:0];
            REG_SCREEN_HEIGHT:  scr_h = value[CFG_BITS-1:0];
            REG_JUMP_THRESHOLD: jump_max = value[CFG_BITS-1:0];
            default:            smooth_on = value[0];
        endcase
    endtask

    // mostly a finger drifting inside the screen; some lifts and wild samples
    task automatic queue_track(input int n);
        int xmax;
        int ymax;
        int reach;
        int pick;
        xmax = (scr_w == 0) ? 0 : ((scr_w > 4096) ? 4095 : int'(scr_w) - 1);
        ymax = (scr_h == 0) ? 0 : ((scr_h > 4096) ? 4095 : int'(scr_h) - 1);
        reach = (jump_max > 800) ? 200 : int'(jump_max) / 4;
        trk_x = $urandom_range(xmax);
        trk_y = $urandom_range(ymax);
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                sample_q.push_back(build_sample(4'd0, 12'($urandom), 12'($urandom),
                                                12'($urandom)));
            end else if (pick < 14) begin
                sample_q.push_back(build_sample(4'($urandom_range(15)), 12'($urandom),
                                                12'($urandom), 12'($urandom)));
            end else begin
                trk_x = trk_x + int'($urandom_range(2 * reach)) - reach;
                trk_y = trk_y + int'($urandom_range(2 * reach)) - reach;
                trk_x = (trk_x < 0) ? 0 : ((trk_x > xmax) ? xmax : trk_x);
                trk_y = (trk_y < 0) ? 0 : ((trk_y > ymax) ? ymax : trk_y);
                sample_q.push_back(build_sample(4'($urandom_range(15, 1)), 12'(trk_x),
                                                12'(trk_y), 12'($urandom)));
            end
        end
    endtask

    // wait until no word is queued, on the bus, or awaited
    task automatic wait_drain;
        while (sample_q.size() != 0 || smp_if.valid || point_q.size() != 0)
            @(negedge i_clk);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
        end else begin
            if (smp_if.valid && smp_if.ready)
                point_q.push_back(filter_point({smp_if.status_byte, smp_if.x_high,
                                                smp_if.x_low, smp_if.y_high, smp_if.y_low}));
            if (!smp_if.valid || smp_if.ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_word = sample_q.pop_front();
                    smp_if.valid <= 1'b1;
                    smp_if.status_byte <= next_word.status_byte;
                    smp_if.x_high <= next_word.x_high;
                    smp_if.x_low <= next_word.x_low;
                    smp_if.y_high <= next_word.y_high;
                    smp_if.y_low <= next_word.y_low;
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // long sink hold-off, counted here
    always @(posedge i_clk) begin
        if (!hold_req)
            hold_cnt <= 0;
        else if (hold_cnt < HOLD_CYCLES)
            hold_cnt <= hold_cnt + 1;
    end

    // result monitor and sink stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pnt_if.ready <= 1'b0;
        end else begin
            if (pnt_if.valid && pnt_if.ready) begin
                if (point_q.size() == 0) begin
                    report_mismatch("word with nothing pending", 1, 0);
                end else begin
                    want = point_q.pop_front();
                    if (pnt_if.point_count !== want.point_count)
                        report_mismatch("point_count", pnt_if.point_count, want.point_count);
                    if (pnt_if.touched !== want.touched)
                        report_mismatch("touched", pnt_if.touched, want.touched);
                    if (pnt_if.accepted !== want.accepted)
                        report_mismatch("accepted", pnt_if.accepted, want.accepted);
                    if (pnt_if.x_out !== want.x_out)
                        report_mismatch("x_out", pnt_if.x_out, want.x_out);
                    if (pnt_if.y_out !== want.y_out)
                        report_mismatch("y_out", pnt_if.y_out, want.y_out);
                end
            end
            pnt_if.ready <= !(hold_req && hold_cnt < HOLD_CYCLES)
                            && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        smp_if.valid = 1'b0;
        smp_if.status_byte = '0;
        smp_if.x_high = '0;
        smp_if.x_low = '0;
        smp_if.y_high = '0;
        smp_if.y_low = '0;
        pnt_if.ready = 1'b0;
    end

    // stimulus phases
    initial begin
        int w;
        int h;
        int thr;
        int sm;
        int words;
        bit hold;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset config 240 x 320, jump 80, smoothing on
        sample_q.push_back(build_sample(4'd0, 12'd0, 12'd0, 12'h000));      // no touch
        sample_q.push_back(build_sample(4'd0, 12'hFFF, 12'hFFF, 12'hFFF));  // no touch, junk
        sample_q.push_back(build_sample(4'd1, 12'd100, 12'd100, 12'h000));  // first point raw
        sample_q.push_back(build_sample(4'd2, 12'd120, 12'd110, 12'h000));  // smoothed
        sample_q.push_back(build_sample(4'd3, 12'd145, 12'd142, 12'h000));  // jump at limit
        sample_q.push_back(build_sample(4'd1, 12'd196, 12'd112, 12'h000));  // one past limit
        sample_q.push_back(build_sample(4'd1, 12'd240, 12'd10, 12'h000));   // x off screen
        sample_q.push_back(build_sample(4'd1, 12'd10, 12'd320, 12'h000));   // y off screen
        sample_q.push_back(build_sample(4'd1, 12'd239, 12'd319, 12'h000));  // jump too large
        sample_q.push_back(build_sample(4'hF, 12'hFFF, 12'hFFF, 12'hFFF));  // max count, off
        sample_q.push_back(build_sample(4'd0, 12'd5, 12'd5, 12'h001));      // lift clears
        sample_q.push_back(build_sample(4'd5, 12'd239, 12'd319, 12'h000));  // corner, raw
        sample_q.push_back(build_sample(4'hF, 12'd239, 12'd319, 12'hFFF));  // same point
        sample_q.push_back(build_sample(4'd1, 12'd0, 12'd0, 12'h000));      // jump too large
        sample_q.push_back(build_sample(4'd0, 12'd0, 12'd0, 12'h000));
        sample_q.push_back(build_sample(4'd1, 12'd0, 12'd0, 12'h000));      // origin, raw
        sample_q.push_back(build_sample(4'd1, 12'd3, 12'd3, 12'h000));      // floors to 0
        sample_q.push_back(build_sample(4'd8, 12'd60, 12'd17, 12'h5A5));

        for (int p = 0; p < 7; p++) begin
            hold = 1'b0;
            case (p)
                0: begin w = 240;  h = 320;  thr = 80;   sm = 1; words = 130;
                   src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin w = 4096; h = 4096; thr = 8191; sm = 0; words = 150;
                   src_idle_pct = 70; snk_stall_pct = 0;  end
                2: begin w = 1;    h = 1;    thr = 0;    sm = 1; words = 100;
                   src_idle_pct = 0;  snk_stall_pct = 70; end
                3: begin w = 0;    h = 0;    thr = 0;    sm = 0; words = 60;
                   src_idle_pct = 33; snk_stall_pct = 33; end
                4: begin w = 800;  h = 480;  thr = 40;   sm = 1; words = 160; hold = 1'b1;
                   src_idle_pct = 33; snk_stall_pct = 33; end
                5: begin w = 4096; h = 100;  thr = 8191; sm = 1; words = 150;
                   src_idle_pct = 0;  snk_stall_pct = 0;  end
                default: begin w = 8191; h = 8191; thr = 200; sm = 0; words = 140;
                   src_idle_pct = 0;  snk_stall_pct = 70; end
            endcase
            if (p != 0) begin
                wait_drain();
                repeat (4) @(negedge i_clk);
                write_reg(REG_SCREEN_WIDTH, w);
                write_reg(REG_SCREEN_HEIGHT, h);
                write_reg(REG_JUMP_THRESHOLD, thr);
                write_reg(REG_SMOOTH_ENABLE, sm);
                @(posedge i_clk);
                i_cfg_we <= 1'b0;
                @(negedge i_clk);
            end
            // sink held off while the source keeps offering, so the filter backs up
            if (hold)
                hold_req = 1'b1;
            queue_track(words);
            if (hold) begin
                while (hold_cnt < HOLD_CYCLES)
                    @(negedge i_clk);
                hold_req = 1'b0;
            end
        end

        wait_drain();
        repeat (8) @(negedge i_clk);
        if (point_q.size() != 0)
            report_mismatch("words never seen", point_q.size(), 0);
        if (err_count == 0)
            $display("touch_point_jump_filter_tb OK");
        else
            $display("touch_point_jump_filter_tb NOT OK");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("timeout waiting for filter results");
        $display("touch_point_jump_filter_tb NOT OK");
        $finish;
    end

endmodule
